// ===== sv/crcfg_pkg.sv =====
// Package with CRC-32 constants, field widths and the byte division function.
`timescale 1ns / 1ps

package crcfg_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned CRC_W  = 32;

    // x^32 term left out; the bit groups follow the polynomial's exponents
    localparam logic [CRC_W-1:0] CRC_POLY =
        (CRC_W'(1) << 26) |
        (CRC_W'(1) << 23) | (CRC_W'(1) << 22) | (CRC_W'(1) << 16) |
        (CRC_W'(1) << 12) | (CRC_W'(1) << 11) | (CRC_W'(1) << 10) | (CRC_W'(1) << 8) |
        (CRC_W'(1) << 7)  | (CRC_W'(1) << 5)  | (CRC_W'(1) << 4)  | (CRC_W'(1) << 2) |
        (CRC_W'(1) << 1)  | CRC_W'(1);

    typedef logic [CRC_W-1:0]  crc_word_t;
    typedef logic [DATA_W-1:0] data_byte_t;

    // Shift one byte into the remainder, MSB first, reducing by the polynomial
    function automatic crc_word_t crc_div_byte(input crc_word_t rem, input data_byte_t din);
        crc_word_t r;
        logic      top;
        r = rem;
        for (int k = DATA_W - 1; k >= 0; k--)
        begin
            top = r[CRC_W-1];
            r   = {r[CRC_W-2:0], din[k]};
            if (top)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/crcfg_if.sv =====
// Valid/ready channel interfaces for frame bytes and frame results.
`timescale 1ns / 1ps

interface crcfg_frame_if;
    logic                       valid;
    logic                       ready;
    logic [crcfg_pkg::DATA_W-1:0] data_byte;
    logic                       is_crc_byte;
    logic                       last_byte;

    modport source (output valid, output data_byte, output is_crc_byte,
                    output last_byte, input ready);
    modport sink   (input valid, input data_byte, input is_crc_byte,
                    input last_byte, output ready);
endinterface

interface crcfg_result_if;
    logic                        valid;
    logic                        ready;
    logic [crcfg_pkg::CRC_W-1:0] remainder_out;
    logic                        crc_match;

    modport source (output valid, output remainder_out, output crc_match, input ready);
    modport sink   (input valid, input remainder_out, input crc_match, output ready);
endinterface

// ===== sv/crc32_frame_generate_check_core.sv =====
// Top level: CRC-32 frame generator and checker, one byte per cycle while no result is stalled.
`timescale 1ns / 1ps

// Channel   Dir  Payload                                 Word accepted when
// -------   ---  --------------------------------------  ------------------------
// frame     in   data_byte[7:0], is_crc_byte, last_byte  frame.valid & frame.ready
// result    out  remainder_out[31:0], crc_match          result.valid & result.ready
//
// One byte per cycle sustained while no result is stalled; a word passes from frame to result
// through the input register, then the eight-step division into the result register.
// Reset clears the remainder, the gathered CRC and all valid flags.
// A stalled result holds the last byte of the next frame in the input register, and the bytes
// behind it wait; bytes before it produce no result and keep flowing while a result waits.

module crc32_frame_generate_check_core (
    input  logic          clk,
    input  logic          rst_n,
    crcfg_frame_if.sink   frame,
    crcfg_result_if.source result
);
    import crcfg_pkg::*;

    // input register stage
    logic       in_valid_reg;
    data_byte_t in_data_reg;
    logic       in_crc_reg;
    logic       in_last_reg;

    // frame state
    crc_word_t  rem_reg;
    crc_word_t  rcv_reg;

    // result register
    logic       out_valid_reg;
    crc_word_t  out_rem_reg;
    logic       out_match_reg;

    logic       consume;
    data_byte_t div_byte;
    crc_word_t  rem_next;
    crc_word_t  rcv_next;

    // The registered byte moves on unless it closes a frame and the result
    // slot is still occupied.
    assign consume = in_valid_reg && (!in_last_reg || !out_valid_reg || result.ready);
    assign frame.ready = !in_valid_reg || consume;

    // CRC-field bytes divide as zero and shift into the received CRC
    assign div_byte = in_crc_reg ? '0 : in_data_reg;
    assign rem_next = crc_div_byte(rem_reg, div_byte);
    assign rcv_next = in_crc_reg ? {rcv_reg[CRC_W-DATA_W-1:0], in_data_reg} : rcv_reg;

    assign result.valid         = out_valid_reg;
    assign result.remainder_out = out_rem_reg;
    assign result.crc_match     = out_match_reg;

    // Capture a new word whenever the input register frees up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (frame.ready)
        begin
            in_valid_reg <= frame.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.ready && frame.valid)
        begin
            in_data_reg <= frame.data_byte;
            in_crc_reg  <= frame.is_crc_byte;
            in_last_reg <= frame.last_byte;
        end
    end

    // Advance the division; on the last byte, drop the state back to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            rcv_reg <= '0;
        end
        else if (consume)
        begin
            if (in_last_reg)
            begin
                rem_reg <= '0;
                rcv_reg <= '0;
            end
            else
            begin
                rem_reg <= rem_next;
                rcv_reg <= rcv_next;
            end
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (consume && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && in_last_reg)
        begin
            out_rem_reg   <= rem_next;
            out_match_reg <= (rem_next == rcv_next);
        end
    end

    // Frame state is clear after a closing byte
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        consume && in_last_reg |=> rem_reg == '0 && rcv_reg == '0)
        else $error("frame state not cleared after last byte");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |-> !(consume && in_last_reg))
        else $error("pending result overwritten");

    // Data bytes leave the gathered CRC alone
    a_rcv_stable: assert property (@(posedge clk) disable iff (!rst_n)
        consume && !in_crc_reg && !in_last_reg |=> $stable(rcv_reg))
        else $error("received CRC changed on a data byte");

    // A closing byte stuck in the input register means the result is stalled
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !consume |-> in_last_reg && out_valid_reg && !result.ready)
        else $error("input stalled without a blocked result");

endmodule
